// ===== hw/rtl/lrusd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrusd_pkg
// Shared types and constants for the LRU stack-distance engine.
// ----------------------------------------------------------------------------
package lrusd_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam int LOAD_ADDR_W = 32;
    localparam int DEPTH_W     = 9;
    localparam int OUT_ADDR_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_LOADED   = 2'd1,
        ST_TOO_DEEP = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FETCH,
        S_SHIFT,
        S_FRONT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic                   command;
        logic [LOAD_ADDR_W-1:0] load_address;
        logic [DEPTH_W-1:0]     stack_depth;
    } req_t;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] accessed_address;
        logic [DEPTH_W-1:0]    depth_used;
        status_t               status;
        logic [COUNT_W-1:0]    entry_count;
    } res_t;

endpackage

// ===== hw/rtl/lrusd_req_if.sv =====
// ----------------------------------------------------------------------------
// lrusd_req_if
// Request channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface lrusd_req_if
    import lrusd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [DEPTH_W-1:0]     stack_depth;

    modport source (output valid, output command, output load_address,
                    output stack_depth, input ready);
    modport sink   (input valid, input command, input load_address,
                    input stack_depth, output ready);
endinterface

// ===== hw/rtl/lrusd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lrusd_rsp_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface lrusd_rsp_if
    import lrusd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [OUT_ADDR_W-1:0] accessed_address;
    logic [DEPTH_W-1:0]    depth_used;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    entry_count;

    modport source (output valid, output accessed_address, output depth_used,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input accessed_address, input depth_used,
                    input status, input entry_count, output ready);
endinterface

// ===== hw/rtl/lrusd_ram.sv =====
// ----------------------------------------------------------------------------
// lrusd_ram
// Stack store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrusd_ram
    import lrusd_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int WIDTH = ADDR_WIDTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lrusd_seq.sv =====
// ----------------------------------------------------------------------------
// lrusd_seq
// Sequencer: decodes a word, then moves stack entries one a cycle through
// the store's single read and write port.
// ----------------------------------------------------------------------------
module lrusd_seq
    import lrusd_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    localparam int IDX_W = $clog2(STACK_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  req_t                  item,
    output logic                  res_valid,
    input  logic                  res_free,
    output res_t                  res,
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output logic [ADDR_WIDTH-1:0] ram_wdata,
    output logic                  ram_re,
    output logic [IDX_W-1:0]      ram_raddr,
    input  logic [ADDR_WIDTH-1:0] ram_rdata
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

    seq_state_t              state_reg,  state_next;
    logic                    cmd_reg,    cmd_next;
    logic [ADDR_WIDTH-1:0]   addr_reg,   addr_next;
    logic [DEPTH_W-1:0]      depth_reg,  depth_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic [IDX_W-1:0]        wptr_reg,   wptr_next;
    logic [ADDR_WIDTH-1:0]   hit_reg,    hit_next;
    status_t                 status_reg, status_next;

    logic [ADDR_WIDTH+LOAD_ADDR_W-1:0] ld_ext;
    logic [OUT_ADDR_W+ADDR_WIDTH-1:0]  hit_ext;
    logic [COUNT_W+CNT_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]                  cmp_depth;
    logic [CMP_W-1:0]                  cmp_count;
    logic [CMP_W-1:0]                  fetch_idx;
    logic [IDX_W-1:0]                  wptr_dec;

    assign ld_ext    = {{ADDR_WIDTH{1'b0}}, item.load_address};
    assign hit_ext   = {{OUT_ADDR_W{1'b0}}, hit_reg};
    assign cnt_ext   = {{COUNT_W{1'b0}}, count_reg};
    assign cmp_depth = CMP_W'(depth_reg);
    assign cmp_count = CMP_W'(count_reg);
    assign fetch_idx = cmp_depth - CMP_W'(1);
    assign wptr_dec  = wptr_reg - IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        depth_reg  <= depth_next;
        wptr_reg   <= wptr_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        depth_next  = depth_reg;
        count_next  = count_reg;
        wptr_next   = wptr_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        item_ready  = 1'b0;
        res_valid   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = addr_reg;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd_next   = item.command;
                    addr_next  = ld_ext[ADDR_WIDTH-1:0];
                    depth_next = (item.stack_depth == '0) ? DEPTH_W'(1) : item.stack_depth;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (cmd_reg == CMD_LOAD)
                begin
                    if (count_reg == CNT_W'(STACK_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = count_reg[IDX_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_LOADED;
                    end
                    state_next = S_DONE;
                end
                else if (cmp_depth > cmp_count)
                begin
                    status_next = ST_TOO_DEEP;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = fetch_idx[IDX_W-1:0];
                    wptr_next   = fetch_idx[IDX_W-1:0];
                    status_next = ST_OK;
                    state_next  = S_FETCH;
                end
            end

            S_FETCH:
            begin
                hit_next = ram_rdata;
                if (wptr_reg == '0)
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = wptr_dec;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = wptr_reg;
                ram_wdata = ram_rdata;
                wptr_next = wptr_dec;
                if (wptr_dec == '0)
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = wptr_dec - IDX_W'(1);
                end
            end

            S_FRONT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = hit_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.accessed_address = (status_reg == ST_OK) ? hit_ext[OUT_ADDR_W-1:0] : '0;
        res.depth_used       = (cmd_reg == CMD_ACCESS) ? depth_reg : '0;
        res.status           = status_reg;
        res.entry_count      = cnt_ext[COUNT_W-1:0];
    end

endmodule

// ===== hw/rtl/lru_stack_depth_access_top.sv =====
// ----------------------------------------------------------------------------
// lru_stack_depth_access_top
// LRU stack-distance engine with move-to-front on access.
// ----------------------------------------------------------------------------
// A load word appends an address at the LRU end, unless the stack is full.
// An access word at depth d (zero taken as one) returns the address there
// and moves it to the MRU end; an access whose depth lies beyond the held
// entries moves nothing. The time an access takes is set by the shift loop,
// which moves one entry per cycle through the stack store's single read and
// single write port. One word is in work at a time; the finished result
// sits in an output register, so the next word is taken while it waits.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module lru_stack_depth_access_top
    import lrusd_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lrusd_req_if.sink  req,
    lrusd_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(STACK_DEPTH);

    req_t                  item;
    res_t                  res;
    logic                  res_valid;
    logic                  res_free;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ADDR_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ADDR_WIDTH-1:0] ram_rdata;

    logic out_valid_reg, out_valid_next;
    res_t out_reg;

    assign item.command      = req.command;
    assign item.load_address = req.load_address;
    assign item.stack_depth  = req.stack_depth;

    lrusd_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_free   (res_free),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    lrusd_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ADDR_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output word register
    assign res_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.accessed_address = out_reg.accessed_address;
    assign rsp.depth_used       = out_reg.depth_used;
    assign rsp.status           = out_reg.status;
    assign rsp.entry_count      = out_reg.entry_count;

endmodule

// ===== bench/lrusd_stack_check.sv =====
// ----------------------------------------------------------------------------
// lrusd_stack_check
// Watches both channels of the LRU stack-distance engine. It keeps its own
// move-to-front stack, works out the result due for every accepted command
// word and compares each accepted result word with the oldest one due.
// ----------------------------------------------------------------------------
module lrusd_stack_check
    import lrusd_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lrusd_req_if req,
    lrusd_rsp_if rsp,
    output int   fail_count,
    output int   pending_results,
    output int   loads_taken,
    output int   loads_refused,
    output int   hits,
    output int   misses,
    output int   deepest_hit
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    logic [ADDR_WIDTH-1:0] lru_order [STACK_DEPTH];
    int unsigned           held;
    res_t                  owed_results [$];

    // index 0 is the MRU end
    function automatic res_t stack_step(input logic                   cmd,
                                        input logic [LOAD_ADDR_W-1:0] addr,
                                        input logic [DEPTH_W-1:0]     depth_in);
        res_t                  due;
        int unsigned           d;
        logic [ADDR_WIDTH-1:0] hit;
        due = '0;
        if (cmd == CMD_LOAD)
        begin
            if (held >= STACK_DEPTH)
                due.status = ST_FULL;
            else
            begin
                lru_order[held] = addr[ADDR_WIDTH-1:0];
                held++;
                due.status = ST_LOADED;
            end
        end
        else
        begin
            d = (depth_in == '0) ? 1 : depth_in;
            due.depth_used = DEPTH_W'(d);
            if (d > held)
                due.status = ST_TOO_DEEP;
            else
            begin
                hit = lru_order[d-1];
                for (int k = d - 1; k > 0; k--)
                    lru_order[k] = lru_order[k-1];
                lru_order[0] = hit;
                due.accessed_address = OUT_ADDR_W'(hit);
                due.status = ST_OK;
            end
        end
        due.entry_count = COUNT_W'(held);
        return due;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            if (fail_count < MAX_REPORTS)
                $display("t=%0t %s mismatch: expected %h, actual %h",
                         $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t due;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                due = stack_step(req.command, req.load_address, req.stack_depth);
                owed_results.push_back(due);
                case (due.status)
                    ST_LOADED:   loads_taken++;
                    ST_FULL:     loads_refused++;
                    ST_TOO_DEEP: misses++;
                    default:
                    begin
                        hits++;
                        if (int'(due.depth_used) > deepest_hit)
                            deepest_hit = due.depth_used;
                    end
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("t=%0t result word with none due: addr %h depth %0d status %0d count %0d",
                                 $time, rsp.accessed_address, rsp.depth_used,
                                 rsp.status, rsp.entry_count);
                    fail_count++;
                end
                else
                begin
                    due = owed_results.pop_front();
                    compare_field("accessed_address", 32'(due.accessed_address),
                                  32'(rsp.accessed_address));
                    compare_field("depth_used", 32'(due.depth_used), 32'(rsp.depth_used));
                    compare_field("status", 32'(due.status), 32'(rsp.status));
                    compare_field("entry_count", 32'(due.entry_count),
                                  32'(rsp.entry_count));
                end
            end
            pending_results = owed_results.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top level for the LRU stack-distance engine. Drives command words in
// bursts, first a directed set of corner cases, then random traffic that
// fills the stack and works it at every depth, with a stalling receiver.
// The checker beside the engine predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    import lrusd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1280;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   hold_request;
    int   loaded;
    int   stall_cycles;

    int fail_count, pending_results;
    int loads_taken, loads_refused, hits, misses, deepest_hit;

    lrusd_req_if req ();
    lrusd_rsp_if rsp ();

    lru_stack_depth_access_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    lrusd_stack_check stack_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .loads_taken     (loads_taken),
        .loads_refused   (loads_refused),
        .hits            (hits),
        .misses          (misses),
        .deepest_hit     (deepest_hit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles = 0;
            else if (++stall_cycles >= STALL_LIMIT)
            begin
                $display("t=%0t no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(input logic                   cmd,
                             input logic [LOAD_ADDR_W-1:0] addr,
                             input logic [DEPTH_W-1:0]     depth);
        @(negedge clk);
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.load_address <= addr;
        req.stack_depth  <= depth;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (cmd == CMD_LOAD && loaded < STACK_DEPTH_DEF)
            loaded++;
    endtask

    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        wait (pending_results == 0);
    endtask

    // receiver: segments of differing stall patterns, plus one long hold-off
    initial
    begin
        int seg_left, seg_cycle, mode, hold_left;
        rsp.ready = 1'b0;
        seg_left  = 0;
        seg_cycle = 0;
        mode      = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                seg_left  = $urandom_range(20, 200);
                mode      = $urandom_range(0, 3);
                seg_cycle = 0;
            end
            seg_left--;
            seg_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= ($urandom_range(0, 9) < 7);
                    2:       rsp.ready <= ($urandom_range(0, 9) < 2);
                    default: rsp.ready <= ((seg_cycle % 8) < 5);
                endcase
            end
        end
    end

    initial
    begin
        int                   gap, burst_left, roll, load_pct;
        logic                 cmd;
        logic [LOAD_ADDR_W-1:0] addr;
        logic [DEPTH_W-1:0]   depth;
        req.valid        = 1'b0;
        req.command      = CMD_LOAD;
        req.load_address = '0;
        req.stack_depth  = '0;
        loaded           = 0;
        burst_left       = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty stack, zero depth, largest depth
        send_word(CMD_ACCESS, 32'hFFFF_FFFF, 9'd0);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd256);
        send_word(CMD_LOAD,   32'h0000_0000, 9'h1FF);
        send_word(CMD_LOAD,   32'hFFFF_FFFF, 9'd0);
        send_word(CMD_LOAD,   32'hA5A5_A5A5, 9'd256);
        send_word(CMD_LOAD,   32'h5A5A_5A5A, 9'd1);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd0);
        send_word(CMD_ACCESS, 32'hFFFF_FFFF, 9'd1);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd4);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd5);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd256);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd2);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd3);
        send_word(CMD_LOAD,   32'h1234_5678, 9'd0);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd5);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd6);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd4);
        send_word(CMD_ACCESS, 32'h0000_0000, 9'd1);
        drain();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 300 || i == 900)
                drain();
            if (i == 350)
            begin
                // long receiver hold-off while words keep coming
                hold_request = 1'b1;
                burst_left   = 16;
            end
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    @(negedge clk);
                    req.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
            end
            burst_left--;

            if (i < 300)
                load_pct = (loaded < 40) ? 35 : 5;
            else if (loaded < STACK_DEPTH_DEF)
                load_pct = 60;
            else
                load_pct = 8;
            cmd = ($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_ACCESS;

            roll = $urandom_range(0, 99);
            if (roll < 5)
                addr = '0;
            else if (roll < 10)
                addr = '1;
            else
                addr = $urandom;

            roll = $urandom_range(0, 99);
            if (roll < 5)
                depth = '0;
            else if (roll < 15 || loaded == 0)
                depth = (loaded >= STACK_DEPTH_DEF)
                      ? DEPTH_W'($urandom_range(0, STACK_DEPTH_DEF))
                      : DEPTH_W'($urandom_range(loaded + 1, STACK_DEPTH_DEF));
            else if (roll < 60)
                depth = DEPTH_W'($urandom_range(1, (loaded < 16) ? loaded : 16));
            else
                depth = DEPTH_W'($urandom_range(1, loaded));

            send_word(cmd, addr, depth);
        end

        drain();
        repeat (STACK_DEPTH_DEF + 16) @(posedge clk);
        $display("Covered %0d loads (%0d refused on a full stack), %0d hits up to depth %0d,",
                 loads_taken, loads_refused, hits, deepest_hit);
        $display("%0d accesses beyond the held entries, one %0d-cycle result hold-off.",
                 misses, HOLD_CYCLES);
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lrusd_pkg.sv
hw/rtl/lrusd_req_if.sv
hw/rtl/lrusd_rsp_if.sv
hw/rtl/lrusd_ram.sv
hw/rtl/lrusd_seq.sv
hw/rtl/lru_stack_depth_access_top.sv
bench/lrusd_stack_check.sv
bench/tb.sv
